// ----- rtl/hhd_pkg.sv -----
// Shared types and constants for the H4 UART deframer.
package hhd_pkg;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_ACL   = 2'd1,
    KIND_SCO   = 2'd2
  } pkt_kind_e;

  localparam logic [1:0] OUT_EVENT = 2'd0;
  localparam logic [1:0] OUT_ACL   = 2'd1;
  localparam logic [1:0] OUT_DROP  = 2'd2;

  localparam logic [2:0] HDR_LEN_EVENT = 3'd2;
  localparam logic [2:0] HDR_LEN_ACL   = 3'd4;
  localparam logic [2:0] HDR_LEN_SCO   = 3'd3;

  localparam logic [1:0] CFG_EVENT_CODE = 2'd0;
  localparam logic [1:0] CFG_ACL_CODE   = 2'd1;
  localparam logic [1:0] CFG_SCO_CODE   = 2'd2;

  localparam logic [7:0] RST_EVENT_CODE = 8'd4;
  localparam logic [7:0] RST_ACL_CODE   = 8'd2;
  localparam logic [7:0] RST_SCO_CODE   = 8'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } queue_item_t;

  function automatic logic [2:0] hdr_len_f(pkt_kind_e kind);
    logic [2:0] len;
    unique case (kind)
      KIND_EVENT: len = HDR_LEN_EVENT;
      KIND_ACL:   len = HDR_LEN_ACL;
      default:    len = HDR_LEN_SCO;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/hhd_front.sv -----
// Front end: type code registers and per-byte packet framing state machine.
module hhd_front
  import hhd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  output queue_item_t item_o
);

  logic [7:0]  evt_code_q, acl_code_q, sco_code_q;
  logic        in_packet_q, in_packet_d;
  pkt_kind_e   kind_q, kind_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] rem_q, rem_d;

  logic        emit;
  logic        last;
  logic [2:0]  hdr_len;
  logic [2:0]  hpos_n;
  logic [15:0] rem_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_code_q <= RST_EVENT_CODE;
      acl_code_q <= RST_ACL_CODE;
      sco_code_q <= RST_SCO_CODE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EVENT_CODE: evt_code_q <= cfg_wdata_i;
        CFG_ACL_CODE:   acl_code_q <= cfg_wdata_i;
        CFG_SCO_CODE:   sco_code_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      kind_q      <= KIND_EVENT;
      hpos_q      <= 3'd0;
      len_lo_q    <= 8'd0;
      rem_q       <= 16'd0;
    end else if (accept_i) begin
      in_packet_q <= in_packet_d;
      kind_q      <= kind_d;
      hpos_q      <= hpos_d;
      len_lo_q    <= len_lo_d;
      rem_q       <= rem_d;
    end
  end

  always_comb begin
    in_packet_d = in_packet_q;
    kind_d      = kind_q;
    hpos_d      = hpos_q;
    len_lo_d    = len_lo_q;
    rem_d       = rem_q;
    emit        = 1'b0;
    last        = 1'b0;
    hdr_len     = hdr_len_f(kind_q);
    hpos_n      = hpos_q;
    rem_n       = rem_q;
    item_o      = '{kind: OUT_DROP, data: rx_byte_i, last: 1'b1};

    if (!in_packet_q) begin
      // event wins over ACL, ACL over SCO
      if (rx_byte_i == evt_code_q || rx_byte_i == acl_code_q ||
          rx_byte_i == sco_code_q) begin
        in_packet_d = 1'b1;
        hpos_d      = 3'd0;
        len_lo_d    = 8'd0;
        rem_d       = 16'd0;
        if (rx_byte_i == evt_code_q) begin
          kind_d = KIND_EVENT;
        end else if (rx_byte_i == acl_code_q) begin
          kind_d = KIND_ACL;
        end else begin
          kind_d = KIND_SCO;
        end
      end else begin
        emit = 1'b1;
      end
    end else begin
      if (hpos_q < hdr_len) begin
        hpos_n = 3'(hpos_q + 3'd1);
        unique case (kind_q)
          KIND_EVENT: begin
            if (hpos_n == 3'd2) rem_n = {8'd0, rx_byte_i};
          end
          KIND_ACL: begin
            if (hpos_n == 3'd3) len_lo_d = rx_byte_i;
            else if (hpos_n == 3'd4) rem_n = {rx_byte_i, len_lo_q};
          end
          default: begin
            if (hpos_n == 3'd3) rem_n = {8'd0, rx_byte_i};
          end
        endcase
        hpos_d = hpos_n;
        last   = (hpos_n >= hdr_len) && (rem_n == 16'd0);
      end else begin
        if (rem_q != 16'd0) rem_n = 16'(rem_q - 16'd1);
        last = (rem_n == 16'd0);
      end
      rem_d = rem_n;
      if (last) in_packet_d = 1'b0;
      emit        = (kind_q == KIND_EVENT) || (kind_q == KIND_ACL);
      item_o.kind = (kind_q == KIND_ACL) ? OUT_ACL : OUT_EVENT;
      item_o.last = last;
    end
  end

  assign push_o = accept_i && emit;

  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && item_o.kind == OUT_DROP |-> item_o.last)
    else $error("drop transfer without last flag");

  a_known_type_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !in_packet_q && !push_o |=> in_packet_q && hpos_q == 3'd0)
    else $error("known type byte did not open a packet");

  a_hpos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_packet_q |-> hpos_q <= hdr_len)
    else $error("header position past header length");

endmodule

// ----- rtl/hhd_queue.sv -----
// Back end: small result queue feeding the output channel.
module hhd_queue
  import hhd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  queue_item_t item_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        ready_i,
  output queue_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  queue_item_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntFull);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      if (pop)    rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      if (push_i && !pop)      count_q <= CntW'(count_q + 1'b1);
      else if (pop && !push_i) count_q <= CntW'(count_q - 1'b1);
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop)
    else $error("push into full queue");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i |=> count_q == CntW'($past(count_q) - 1'b1))
    else $error("pop did not reduce count");

endmodule

// ----- rtl/hci_h4_uart_deframer.sv -----
// Top level of the H4 UART deframer: front-end framer plus result queue.
//
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_byte_i) takes one received UART
//   byte per transfer. The framer tracks type byte, header and payload
//   length, and each accepted byte yields zero or one result.
//   out channel (out_valid_o/out_ready_i) gives out_kind_o (event, ACL or
//   dropped unknown type), out_byte_o and out_last_o. SCO packets and
//   known type bytes produce no result.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the event, ACL and SCO type codes;
//   write only while idle.
// Timing:
//   One byte is accepted per cycle while rx_ready_o is high; a result is
//   queued on its byte transfer and shown once earlier results are taken.
//   Throughput is set by the framer update and the QueueDepth-entry queue.
// Reset:
//   Type codes return to 4/2/3, the framer waits for a type byte and the
//   queue is emptied.
// Stall:
//   When out_ready_i is low the queue fills; rx_ready_o drops once it holds
//   QueueDepth results and returns as soon as one is taken.
module hci_h4_uart_deframer
  import hhd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic        accept;
  logic        push;
  logic        full;
  queue_item_t front_item;
  queue_item_t back_item;

  assign rx_ready_o = !full;
  assign accept     = rx_valid_i && rx_ready_o;

  hhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .item_o      (front_item)
  );

  hhd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (back_item)
  );

  assign out_kind_o = back_item.kind;
  assign out_byte_o = back_item.data;
  assign out_last_o = back_item.last;

endmodule

// ----- bench/hci_h4_uart_deframer_tb.sv -----
// Self-checking testbench for the H4 UART deframer: random byte streams against a packet model.
module hci_h4_uart_deframer_tb;
  import hhd_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic       rx_valid_i = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  hci_h4_uart_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // packet model state
  logic [7:0]  code_event = RST_EVENT_CODE;
  logic [7:0]  code_acl = RST_ACL_CODE;
  logic [7:0]  code_sco = RST_SCO_CODE;
  logic        frm_busy = 1'b0;
  pkt_kind_e   frm_kind = KIND_EVENT;
  logic [2:0]  frm_hdr_pos = '0;
  logic [7:0]  frm_len_lo = '0;
  logic [15:0] frm_remaining = '0;

  queue_item_t exp_results[$];
  logic [7:0]  tx_bytes[$];
  queue_item_t want_item;

  logic        rx_xfer = 1'b0;
  logic        out_xfer = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned tx_left = 0;
  bit          tx_calm = 1'b0;
  int unsigned sink_gap = 0;
  int unsigned sink_left = 0;
  bit          sink_calm = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned n_err = 0;
  int unsigned n_sent = 0;
  int unsigned n_event = 0;
  int unsigned n_acl = 0;
  int unsigned n_drop = 0;
  int unsigned n_cfg = 1;

  function automatic logic [2:0] header_bytes(input pkt_kind_e k);
    case (k)
      KIND_EVENT: return HDR_LEN_EVENT;
      KIND_ACL:   return HDR_LEN_ACL;
      default:    return HDR_LEN_SCO;
    endcase
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic       last;
    logic [2:0] hlen;
    last = 1'b0;
    if (!frm_busy) begin
      if (b == code_event) begin
        frm_kind = KIND_EVENT;
      end else if (b == code_acl) begin
        frm_kind = KIND_ACL;
      end else if (b == code_sco) begin
        frm_kind = KIND_SCO;
      end else begin
        exp_results.push_back('{kind: OUT_DROP, data: b, last: 1'b1});
        return;
      end
      frm_busy = 1'b1;
      frm_hdr_pos = '0;
      frm_len_lo = '0;
      frm_remaining = '0;
      return;
    end
    hlen = header_bytes(frm_kind);
    if (frm_hdr_pos < hlen) begin
      frm_hdr_pos = frm_hdr_pos + 3'd1;
      case (frm_kind)
        KIND_EVENT: if (frm_hdr_pos == 3'd2) frm_remaining = {8'd0, b};
        KIND_ACL: begin
          if (frm_hdr_pos == 3'd3) frm_len_lo = b;
          else if (frm_hdr_pos == 3'd4) frm_remaining = {b, frm_len_lo};
        end
        default: if (frm_hdr_pos == 3'd3) frm_remaining = {8'd0, b};
      endcase
      if (frm_hdr_pos >= hlen && frm_remaining == 16'd0) last = 1'b1;
    end else begin
      if (frm_remaining != 16'd0) frm_remaining = frm_remaining - 16'd1;
      if (frm_remaining == 16'd0) last = 1'b1;
    end
    if (last) frm_busy = 1'b0;
    if (frm_kind == KIND_EVENT) begin
      exp_results.push_back('{kind: OUT_EVENT, data: b, last: last});
    end else if (frm_kind == KIND_ACL) begin
      exp_results.push_back('{kind: OUT_ACL, data: b, last: last});
    end
  endtask

  task automatic next_gap(inout bit calm, inout int unsigned left, output int unsigned gap);
    int unsigned r;
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(20, 200);
    end else begin
      left--;
    end
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 94) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!rx_valid_i || rx_xfer)) begin
      if (rx_valid_i) next_gap(tx_calm, tx_left, tx_gap);
      if (tx_gap != 0 || tx_bytes.size() == 0) begin
        rx_valid_i <= 1'b0;
        if (tx_gap != 0) tx_gap--;
      end else begin
        rx_valid_i <= 1'b1;
        rx_byte_i <= tx_bytes.pop_front();
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer || $urandom_range(0, 15) == 0) next_gap(sink_calm, sink_left, sink_gap);
      if (sink_gap != 0) begin
        out_ready_i <= 1'b0;
        sink_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_xfer <= rx_valid_i && rx_ready_o;
      out_xfer <= out_valid_o && out_ready_i;
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_byte_i);
        n_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        if (exp_results.size() == 0) begin
          $error("unexpected result: out_kind %0d out_byte %02h out_last %0d",
                 out_kind_o, out_byte_o, out_last_o);
          n_err++;
        end else begin
          want_item = exp_results.pop_front();
          if (out_kind_o !== want_item.kind) begin
            $error("out_kind: expected %0d, got %0d", want_item.kind, out_kind_o);
            n_err++;
          end
          if (out_byte_o !== want_item.data) begin
            $error("out_byte: expected %02h, got %02h", want_item.data, out_byte_o);
            n_err++;
          end
          if (out_last_o !== want_item.last) begin
            $error("out_last: expected %0d, got %0d", want_item.last, out_last_o);
            n_err++;
          end
          case (want_item.kind)
            OUT_EVENT: n_event++;
            OUT_ACL:   n_acl++;
            default:   n_drop++;
          endcase
        end
      end
      if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || rx_valid_i || exp_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EVENT_CODE: code_event = val;
      CFG_ACL_CODE:   code_acl = val;
      CFG_SCO_CODE:   code_sco = val;
      default:        ;
    endcase
  endtask

  task automatic write_codes(input logic [7:0] ev, input logic [7:0] acl,
                             input logic [7:0] sco);
    write_reg(CFG_EVENT_CODE, ev);
    write_reg(CFG_ACL_CODE, acl);
    write_reg(CFG_SCO_CODE, sco);
    n_cfg++;
  endtask

  task automatic add_packet(input pkt_kind_e k, input logic [15:0] len, input bit cut,
                            inout int unsigned cnt);
    logic [7:0]  pkt[$];
    int unsigned keep;
    case (k)
      KIND_EVENT: begin
        pkt.push_back(code_event);
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(len[7:0]);
      end
      KIND_ACL: begin
        pkt.push_back(code_acl);
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(len[7:0]);
        pkt.push_back(len[15:8]);
      end
      default: begin
        pkt.push_back(code_sco);
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(len[7:0]);
      end
    endcase
    for (int unsigned i = 0; i < len; i++) pkt.push_back(8'($urandom_range(0, 255)));
    keep = cut ? $urandom_range(1, pkt.size() - 1) : pkt.size();
    for (int unsigned i = 0; i < keep; i++) tx_bytes.push_back(pkt[i]);
    cnt += keep;
  endtask

  task automatic add_traffic(input int unsigned n_items);
    int unsigned n;
    int unsigned r;
    logic [15:0] len;
    bit          cut;
    n = 0;
    while (n < n_items) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 255)) :
                                          16'($urandom_range(0, 6));
      cut = ($urandom_range(0, 19) == 0);
      if (r < 30) begin
        add_packet(KIND_EVENT, len, cut, n);
      end else if (r < 60) begin
        if ($urandom_range(0, 9) == 0) len[8] = 1'b1;
        add_packet(KIND_ACL, len, cut, n);
      end else if (r < 80) begin
        add_packet(KIND_SCO, len, cut, n);
      end else begin
        tx_bytes.push_back(8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  initial begin
    logic [7:0]  dir_seq[25];
    int unsigned n_dummy;
    dir_seq = '{RST_EVENT_CODE, 8'h0E, 8'h00,
                RST_EVENT_CODE, 8'hFF, 8'h02, 8'hAA, 8'h55,
                RST_ACL_CODE, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h80,
                RST_SCO_CODE, 8'h11, 8'h22, 8'h00,
                8'h00, 8'hFF,
                RST_ACL_CODE, 8'h00, 8'h00, 8'h00, 8'h00};
    n_dummy = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset codes: directed packets, then random traffic
    foreach (dir_seq[i]) tx_bytes.push_back(dir_seq[i]);
    add_traffic(130);
    wait_idle();

    // extreme codes and a write to the unused index
    write_codes(8'h00, 8'hFF, 8'h80);
    write_reg(CFG_UNUSED, 8'hFF);
    add_traffic(100);
    wait_idle();

    // codes rewritten in the middle of an ACL header
    tx_bytes.push_back(code_acl);
    tx_bytes.push_back(8'h5A);
    tx_bytes.push_back(8'hA5);
    wait_idle();
    write_codes(8'hFF, 8'h7E, 8'h00);
    tx_bytes.push_back(8'h03);
    tx_bytes.push_back(8'h00);
    for (int i = 0; i < 3; i++) tx_bytes.push_back(8'($urandom_range(0, 255)));
    wait_idle();

    // equal codes: event over ACL, then ACL over SCO
    write_codes(8'h55, 8'h55, 8'h55);
    add_traffic(100);
    wait_idle();
    write_codes(8'h01, 8'hAA, 8'hAA);
    add_traffic(100);
    wait_idle();

    repeat (2) begin
      write_codes(8'($urandom_range(0, 85)), 8'($urandom_range(86, 170)),
                  8'($urandom_range(171, 255)));
      add_traffic(80);
      wait_idle();
    end

    // one ACL packet whose length needs the high length byte
    write_codes(RST_EVENT_CODE, RST_ACL_CODE, RST_SCO_CODE);
    add_packet(KIND_ACL, {8'h01, 8'($urandom_range(0, 63))}, 1'b0, n_dummy);
    add_traffic(50);
    wait_idle();

    if (exp_results.size() != 0) begin
      $error("%0d expected results never arrived", exp_results.size());
      n_err++;
    end
    $display("Summary: %0d bytes sent; %0d event, %0d ACL and %0d drop results checked",
             n_sent, n_event, n_acl, n_drop);
    $display("Summary: %0d type-code settings incl. extremes, equal codes, mid-packet writes",
             n_cfg);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
